// File: sv/srb_pkg.sv
// ----------------------------------------------------------------------------
// Sample ring buffer package
// Shared constants, command and payload types for the sample ring buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int DEPTH       = 4096;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int MAX_BURST   = 64;
    localparam int TAIL_WINDOW = 16;
    localparam int COUNT_W     = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_BURST = 2'd2;
    localparam logic [1:0] MODE_DIST  = 2'd3;

    localparam logic [ADDR_W-1:0] TAIL_START = ADDR_W'(DEPTH - TAIL_WINDOW);
    localparam logic [COUNT_W-1:0] BURST_MAX = COUNT_W'(MAX_BURST);

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_BURST,
        OP_DIST
    } t_op;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        address;
        logic signed [15:0] sample_in;
        logic [6:0]         count;
        logic [11:0]        interval;
        logic [11:0]        delay;
    } t_item;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic [11:0]        distance;
        logic               last;
    } t_result;

    typedef struct packed {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        logic signed [15:0] sample;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0]  interval;
        logic [ADDR_W-1:0]  delay;
    } t_cmd;

endpackage

// File: sv/srb_front.sv
// ----------------------------------------------------------------------------
// Sample ring buffer front end
// Accepts transactions, decodes the mode, reduces the address to the ring
// and saturates the burst count before queueing the command.
// ----------------------------------------------------------------------------
module srb_front (
    input  logic          i_start,
    input  srb_pkg::t_item i_item,
    input  logic          i_full,
    output logic          o_busy,
    output logic          o_push,
    output srb_pkg::t_cmd o_cmd
);
    import srb_pkg::*;

    always_comb begin
        o_busy        = i_full;
        o_push        = i_start && !i_full;
        o_cmd.addr    = i_item.address[ADDR_W-1:0];
        o_cmd.sample  = i_item.sample_in;
        o_cmd.interval = i_item.interval[ADDR_W-1:0];
        o_cmd.delay   = i_item.delay[ADDR_W-1:0];
        o_cmd.count   = (i_item.count > BURST_MAX) ? BURST_MAX : i_item.count;
        unique case (i_item.mode)
            MODE_WRITE: o_cmd.op = OP_WRITE;
            MODE_READ:  o_cmd.op = OP_READ;
            MODE_BURST: o_cmd.op = OP_BURST;
            MODE_DIST:  o_cmd.op = OP_DIST;
            default:    o_cmd.op = OP_WRITE;
        endcase
    end

endmodule

// File: sv/srb_queue.sv
// ----------------------------------------------------------------------------
// Sample ring buffer command queue
// Short first-in first-out queue between the front end and the executor.
// ----------------------------------------------------------------------------
module srb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srb_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output srb_pkg::t_cmd o_head
);
    import srb_pkg::*;

    localparam logic [QUEUE_CW-1:0] FULL_CNT = QUEUE_CW'(QUEUE_DEPTH);

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_CW-1:0] r_cnt;
    logic [QUEUE_CW-1:0] n_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rptr];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

// File: sv/srb_back.sv
// ----------------------------------------------------------------------------
// Sample ring buffer executor
// Owns the sample memory and the most recent address, carries out writes,
// single reads, burst reads and distance queries, one memory access a cycle.
// ----------------------------------------------------------------------------
module srb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  srb_pkg::t_cmd   i_head,
    output logic            o_pop,
    output logic            o_valid,
    output srb_pkg::t_result o_result
);
    import srb_pkg::*;

    logic signed [15:0]  r_mem [DEPTH];
    logic signed [15:0]  r_rd_data;

    logic                r_active;
    logic                n_active;
    logic [ADDR_W-1:0]   r_ptr;
    logic [ADDR_W-1:0]   n_ptr;
    logic [ADDR_W-1:0]   r_step;
    logic [ADDR_W-1:0]   n_step;
    logic [COUNT_W-1:0]  r_left;
    logic [COUNT_W-1:0]  n_left;
    logic [ADDR_W-1:0]   r_newest;
    logic [ADDR_W-1:0]   n_newest;

    logic                r_o_valid;
    logic                r_o_last;
    logic                r_o_is_dist;
    logic [ADDR_W-1:0]   r_o_dist;

    logic                iss_valid;
    logic                iss_last;
    logic                iss_is_dist;
    logic [ADDR_W-1:0]   iss_dist;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   burst_start;

    always_comb begin
        n_active    = r_active;
        n_ptr       = r_ptr;
        n_step      = r_step;
        n_left      = r_left;
        n_newest    = r_newest;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        iss_valid   = 1'b0;
        iss_last    = 1'b0;
        iss_is_dist = 1'b0;
        iss_dist    = '0;
        rd_addr     = r_ptr;
        burst_start = r_newest - i_head.delay;
        if (r_active) begin
            iss_valid = 1'b1;
            iss_last  = (r_left == COUNT_W'(1));
            n_ptr     = r_ptr - r_step;
            n_left    = r_left - 1'b1;
            if (r_left == COUNT_W'(1)) begin
                n_active = 1'b0;
            end
        end else if (!i_empty) begin
            o_pop = 1'b1;
            unique case (i_head.op)
                OP_WRITE: begin
                    wr_en = 1'b1;
                    if (r_newest >= TAIL_START) begin
                        n_newest = i_head.addr;
                    end else if (i_head.addr > r_newest) begin
                        n_newest = i_head.addr;
                    end
                end
                OP_READ: begin
                    iss_valid = 1'b1;
                    iss_last  = 1'b1;
                    rd_addr   = i_head.addr;
                end
                OP_BURST: begin
                    rd_addr = burst_start;
                    if (i_head.count != '0) begin
                        iss_valid = 1'b1;
                        iss_last  = (i_head.count == COUNT_W'(1));
                    end
                    if (i_head.count > COUNT_W'(1)) begin
                        n_active = 1'b1;
                        n_ptr    = burst_start - i_head.interval;
                        n_step   = i_head.interval;
                        n_left   = i_head.count - 1'b1;
                    end
                end
                OP_DIST: begin
                    iss_valid   = 1'b1;
                    iss_last    = 1'b1;
                    iss_is_dist = 1'b1;
                    iss_dist    = r_newest - i_head.addr;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_left    <= '0;
            r_newest  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_active  <= n_active;
            r_left    <= n_left;
            r_newest  <= n_newest;
            r_o_valid <= iss_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_step      <= n_step;
        r_o_last    <= iss_last;
        r_o_is_dist <= iss_is_dist;
        r_o_dist    <= iss_dist;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_head.addr] <= i_head.sample;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        o_valid             = r_o_valid;
        o_result.sample_out = r_o_is_dist ? 16'sd0 : r_rd_data;
        o_result.distance   = 12'(r_o_dist);
        o_result.last       = r_o_last;
    end

endmodule

// File: sv/sample_ring_buffer_decimated_readout.sv
// ----------------------------------------------------------------------------
// Sample ring buffer with decimated burst readout
// Top level: front end, command queue and executor with the sample memory.
// ----------------------------------------------------------------------------
// Read and distance results leave through a register at the executor output.
// Writes, reads and distance queries are each done as the queue pops them.
// A burst of count samples holds the executor until its last sample is read.
// A four-entry command queue absorbs bursts; busy is high while it is full.
// Synchronous reset clears the queue, the executor and the most recent address.
// Sample memory contents are undefined after reset until written.
// ----------------------------------------------------------------------------
module sample_ring_buffer_decimated_readout (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  srb_pkg::t_item   i_item,
    output logic             o_valid,
    output srb_pkg::t_result o_result
);
    import srb_pkg::*;

    logic full;
    logic empty;
    logic push;
    logic pop;
    t_cmd cmd;
    t_cmd head;

    srb_front u_front (
        .i_start (start),
        .i_item  (i_item),
        .i_full  (full),
        .o_busy  (busy),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    srb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    srb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
